// File: rtl/lbs_pkg.sv
// Package: types, constants and helpers shared by the skinning block.
package lbs_pkg;

  localparam int unsigned LBS_BONES      = 256;
  localparam int unsigned LBS_INFLUENCES = 4;
  localparam int unsigned WORDS_PER_BONE = 12;
  localparam int unsigned MAX_FIELDS     = 4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SKIN = 1'b1;

  // 12-bit address divided by twelve: (addr * 2731) >> 15 is exact below 4096.
  localparam logic [11:0] DIV12_MUL   = 12'd2731;
  localparam int unsigned DIV12_SHIFT = 15;

  typedef struct packed {
    logic               cmd;
    logic [11:0]        mat_addr;
    logic signed [31:0] mat_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic [31:0]        bone_ids;
    logic [31:0]        weights_lo;
    logic [31:0]        weights_hi;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_nrm_x;
    logic signed [31:0] out_nrm_y;
    logic signed [31:0] out_nrm_z;
  } out_t;

  // per-influence control traveling down the pipeline
  typedef struct packed {
    logic        vld;
    logic        first;
    logic        last;
    logic        ok;
    logic [15:0] w;
  } ctl_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/lbs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module lbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lbs_xform.sv
// Per-influence matrix transform: products, then row sums with rounding.
module lbs_xform (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  lbs_pkg::ctl_t       ctl_i,
  input  logic [5:0][31:0]    vec_i,
  input  logic [11:0][31:0]   mat_i,
  output lbs_pkg::ctl_t       ctl_o,
  output logic [5:0][31:0]    res_o
);

  logic signed [63:0] prod_d [18];
  logic signed [63:0] prod_q [18];
  logic [2:0][31:0]   col3_q;
  lbs_pkg::ctl_t      ctl_a_q, ctl_b_q;
  logic [5:0][31:0]   res_d, res_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r*3+c]   = $signed(mat_i[r*4+c]) * $signed(vec_i[c]);
        prod_d[9+r*3+c] = $signed(mat_i[r*4+c]) * $signed(vec_i[3+c]);
      end
    end
  end

  always_comb begin
    logic signed [65:0] sp, sn, tp, tn;
    for (int r = 0; r < 3; r++) begin
      sp = 66'(prod_q[r*3]) + 66'(prod_q[r*3+1]) + 66'(prod_q[r*3+2]) + 66'sd32768;
      sn = 66'(prod_q[9+r*3]) + 66'(prod_q[9+r*3+1]) + 66'(prod_q[9+r*3+2])
         + 66'sd32768;
      tp = (sp >>> 16) + 66'($signed(col3_q[r]));
      tn = sn >>> 16;
      res_d[r]   = lbs_pkg::sat32(tp);
      res_d[3+r] = lbs_pkg::sat32(tn);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 18; i++) begin
        prod_q[i] <= prod_d[i];
      end
      for (int r = 0; r < 3; r++) begin
        col3_q[r] <= mat_i[r*4+3];
      end
      res_q <= res_d;
    end
  end

  assign ctl_o = ctl_b_q;
  assign res_o = res_q;

endmodule

// File: rtl/lbs_blend.sv
// Weighting, accumulation over influences and the output register.
module lbs_blend (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  lbs_pkg::ctl_t    ctl_i,
  input  logic [5:0][31:0] t_i,
  output logic             out_valid_o,
  output lbs_pkg::out_t    out_data_o
);

  logic signed [48:0] wp_q  [6];
  logic signed [51:0] acc_q [6];
  logic signed [51:0] acc_d [6];
  lbs_pkg::ctl_t      ctl_c_q;
  logic               done_q, vld_q;
  logic [5:0][31:0]   dat_d, dat_q;

  always_comb begin
    logic signed [51:0] base;
    for (int i = 0; i < 6; i++) begin
      base     = ctl_c_q.first ? 52'sd0 : acc_q[i];
      acc_d[i] = ctl_c_q.ok ? base + 52'(wp_q[i]) : base;
    end
  end

  always_comb begin
    logic signed [51:0] rnd;
    for (int i = 0; i < 6; i++) begin
      rnd      = (acc_q[i] + 52'sd16384) >>> 15;
      dat_d[i] = lbs_pkg::sat32(66'(rnd));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c_q <= '0;
      done_q  <= 1'b0;
      vld_q   <= 1'b0;
    end else if (en_i) begin
      ctl_c_q <= ctl_i;
      done_q  <= ctl_c_q.vld && ctl_c_q.last;
      vld_q   <= done_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) begin
        wp_q[i] <= $signed(t_i[i]) * $signed({1'b0, ctl_i.w});
        if (ctl_c_q.vld) begin
          acc_q[i] <= acc_d[i];
        end
      end
      if (done_q) begin
        dat_q <= dat_d;
      end
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = {dat_q[0], dat_q[1], dat_q[2], dat_q[3], dat_q[4], dat_q[5]};

endmodule

// File: rtl/linear_blend_skinning_top.sv
// Top level: bone matrix store in twelve banks, influence sequencer, pipeline.
//
//  channel | valid        | stall        | payload
//  input   | in_valid_i   | in_stall_o   | in_data_i  (lbs_pkg::in_t)
//  output  | out_valid_o  | out_stall_i  | out_data_o (lbs_pkg::out_t)
//
// A skin transaction reads min(INFLUENCES,4) bone matrices (twelve words, one per
// bank), one per cycle unless the output stalls; a load transaction writes one word.
// After the last read: product, row-sum, weight, accumulator and output registers.
// Reset clears control only; the matrix store is undefined until loaded.
// An output stall freezes the whole pipeline, including the bank read registers.
module linear_blend_skinning_top #(
  parameter int unsigned BONES      = lbs_pkg::LBS_BONES,
  parameter int unsigned INFLUENCES = lbs_pkg::LBS_INFLUENCES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lbs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lbs_pkg::out_t out_data_o
);

  localparam int unsigned AW    = (BONES > 1) ? $clog2(BONES) : 1;
  localparam int unsigned NI    = (INFLUENCES < lbs_pkg::MAX_FIELDS) ?
                                  INFLUENCES : lbs_pkg::MAX_FIELDS;
  localparam logic [1:0]  KLAST = 2'(NI - 1);
  localparam logic [11:0] DEPTH = 12'(BONES * lbs_pkg::WORDS_PER_BONE);
  localparam int unsigned NW    = lbs_pkg::WORDS_PER_BONE;

  logic          adv, accept, acc_load, acc_skin;
  logic          busy_q, busy_d;
  logic [1:0]    k_q, k_d;
  lbs_pkg::in_t  it_q;

  logic [7:0]    bone_k;
  logic [15:0]   w_k;
  logic [23:0]   div_prod;
  logic [8:0]    ld_bone;
  logic [3:0]    ld_word;
  logic          ld_ok;
  logic [NW-1:0] we;

  lbs_pkg::ctl_t    ctl_s1_q, ctl_s1_d, ctl_x;
  logic [5:0][31:0] vec_q, t_x;
  logic [11:0][31:0] rdata;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv || (busy_q && (k_q != KLAST));
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_load   = accept && (in_data_i.cmd == lbs_pkg::CMD_LOAD);
  assign acc_skin   = accept && (in_data_i.cmd == lbs_pkg::CMD_SKIN);

  // load address split into bone and word
  assign div_prod = 24'(in_data_i.mat_addr) * 24'(lbs_pkg::DIV12_MUL);
  assign ld_bone  = div_prod[lbs_pkg::DIV12_SHIFT +: 9];
  assign ld_word  = 4'(in_data_i.mat_addr - 12'(ld_bone) * 12'd12);
  assign ld_ok    = in_data_i.mat_addr < DEPTH;

  always_comb begin
    for (int j = 0; j < NW; j++) begin
      we[j] = acc_load && ld_ok && (ld_word == 4'(j));
    end
  end

  always_comb begin
    bone_k = it_q.bone_ids[8*k_q +: 8];
    case (k_q)
      2'd0:    w_k = it_q.weights_lo[15:0];
      2'd1:    w_k = it_q.weights_lo[31:16];
      2'd2:    w_k = it_q.weights_hi[15:0];
      default: w_k = it_q.weights_hi[31:16];
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (adv && busy_q) begin
      if (k_q == KLAST) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q + 2'd1;
      end
    end
    if (acc_skin) begin
      busy_d = 1'b1;
      k_d    = 2'd0;
    end
  end

  always_comb begin
    ctl_s1_d.vld   = busy_q;
    ctl_s1_d.first = (k_q == 2'd0);
    ctl_s1_d.last  = (k_q == KLAST);
    ctl_s1_d.ok    = 9'(bone_k) < 9'(BONES);
    ctl_s1_d.w     = w_k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      k_q      <= '0;
      ctl_s1_q <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
      if (adv) begin
        ctl_s1_q <= ctl_s1_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_skin) begin
      it_q <= in_data_i;
    end
    if (adv) begin
      vec_q <= {it_q.nrm_z, it_q.nrm_y, it_q.nrm_x, it_q.pos_z, it_q.pos_y, it_q.pos_x};
    end
  end

  for (genvar j = 0; j < NW; j++) begin : g_bank
    lbs_ram #(
      .WIDTH(32),
      .DEPTH(BONES),
      .AW   (AW)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (we[j]),
      .waddr_i(ld_bone[AW-1:0]),
      .wdata_i(in_data_i.mat_value),
      .re_i   (adv),
      .raddr_i(bone_k[AW-1:0]),
      .rdata_o(rdata[j])
    );
  end

  lbs_xform u_xform (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .ctl_i (ctl_s1_q),
    .vec_i (vec_q),
    .mat_i (rdata),
    .ctl_o (ctl_x),
    .res_o (t_x)
  );

  lbs_blend u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .ctl_i      (ctl_x),
    .t_i        (t_x),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!busy_q || (k_q == KLAST)))
    else $error("transaction accepted mid-sequence");

  a_one_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(we))
    else $error("more than one bank written");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(k_q) && $stable(busy_q)))
    else $error("sequencer moved while stalled");

endmodule

// File: bench/lbs_checker.sv
// Checker: watches both channels, predicts skinned vertices and compares them.
module lbs_checker (
  input  logic          clk_i,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  lbs_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  lbs_pkg::out_t out_data_i,
  output int            errors_o,
  output int            pending_o
);

  localparam int unsigned DEPTH = lbs_pkg::LBS_BONES * lbs_pkg::WORDS_PER_BONE;
  localparam int unsigned USED  = (lbs_pkg::LBS_INFLUENCES < 4) ? lbs_pkg::LBS_INFLUENCES : 4;

  logic [31:0]   bone_words [DEPTH];
  lbs_pkg::out_t skinned_q [$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic lbs_pkg::out_t skin_vertex(input lbs_pkg::in_t d);
    logic signed [31:0] vec [6];
    logic signed [65:0] acc [6];
    logic signed [65:0] s;
    logic signed [65:0] w;
    logic signed [31:0] t;
    logic signed [31:0] res [6];
    int unsigned bone, base;
    lbs_pkg::out_t o;
    vec[0] = d.pos_x; vec[1] = d.pos_y; vec[2] = d.pos_z;
    vec[3] = d.nrm_x; vec[4] = d.nrm_y; vec[5] = d.nrm_z;
    for (int i = 0; i < 6; i++) acc[i] = '0;
    for (int k = 0; k < USED; k++) begin
      bone = d.bone_ids[8*k +: 8];
      w = (k < 2) ? 66'(d.weights_lo[16*k +: 16]) : 66'(d.weights_hi[16*(k-2) +: 16]);
      if (bone >= lbs_pkg::LBS_BONES) continue;
      base = bone * lbs_pkg::WORDS_PER_BONE;
      for (int h = 0; h < 2; h++) begin
        for (int r = 0; r < 3; r++) begin
          s = '0;
          for (int c = 0; c < 3; c++) begin
            s = s + 66'($signed(bone_words[base + r*4 + c])) * 66'(vec[h*3 + c]);
          end
          s = (s + 66'sd32768) >>> 16;
          if (h == 0) s = s + 66'($signed(bone_words[base + r*4 + 3]));
          t = clamp32(s);
          acc[h*3 + r] = acc[h*3 + r] + 66'(t) * w;
        end
      end
    end
    for (int i = 0; i < 6; i++) res[i] = clamp32((acc[i] + 66'sd16384) >>> 15);
    o.out_pos_x = res[0]; o.out_pos_y = res[1]; o.out_pos_z = res[2];
    o.out_nrm_x = res[3]; o.out_nrm_y = res[4]; o.out_nrm_z = res[5];
    return o;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors_o++;
  endtask

  task automatic cmp(input string f, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %h expected %h", f, got, want));
  endtask

  always @(posedge clk_i) begin
    lbs_pkg::out_t e;
    if (in_valid_i && !in_stall_i) begin
      if (in_data_i.cmd == lbs_pkg::CMD_LOAD) begin
        if (in_data_i.mat_addr < DEPTH) begin
          bone_words[in_data_i.mat_addr] = in_data_i.mat_value;
        end
      end else begin
        skinned_q.push_back(skin_vertex(in_data_i));
      end
    end
    if (out_valid_i && !out_stall_i) begin
      if (skinned_q.size() == 0) begin
        report("result with no transaction waiting");
      end else begin
        e = skinned_q.pop_front();
        cmp("out_pos_x", out_data_i.out_pos_x, e.out_pos_x);
        cmp("out_pos_y", out_data_i.out_pos_y, e.out_pos_y);
        cmp("out_pos_z", out_data_i.out_pos_z, e.out_pos_z);
        cmp("out_nrm_x", out_data_i.out_nrm_x, e.out_nrm_x);
        cmp("out_nrm_y", out_data_i.out_nrm_y, e.out_nrm_y);
        cmp("out_nrm_z", out_data_i.out_nrm_z, e.out_nrm_z);
      end
    end
    pending_o = skinned_q.size();
  end
endmodule

// File: bench/tb.sv
// Testbench top: matrix loads and vertex skin stimulus, handshake pressure, verdict.
module tb;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  lbs_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  lbs_pkg::out_t out_data;
  int    errors, pending;
  int    tx_idle_pct = 0, rx_idle_pct = 0, hold_cnt = 0;
  int    cycles = 0;
  bit    bone_full [lbs_pkg::LBS_BONES];
  int    full_bones [$];

  always #10 clk = ~clk;

  linear_blend_skinning_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  lbs_checker chk (
    .clk_i(clk), .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic logic [31:0] pick_value(input bit matrix);
    logic [31:0] v;
    case ($urandom_range(9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = 32'h0;
      3, 4: v = $urandom;
      default: v = matrix ? 32'(int'($urandom_range(131072)) - 65536)
                          : 32'(int'($urandom_range(1 << 24)) - (1 << 23));
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_weight();
    logic [15:0] w;
    case ($urandom_range(7))
      0: w = 16'h0;
      1: w = 16'hFFFF;
      2: w = 16'h8000;
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  task automatic send(input lbs_pkg::in_t d);
    in_data  <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic load_word(input int unsigned addr, input logic [31:0] v);
    lbs_pkg::in_t d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, 13'($urandom)};
    d.cmd = lbs_pkg::CMD_LOAD;
    d.mat_addr = 12'(addr);
    d.mat_value = v;
    send(d);
  endtask

  task automatic load_bone(input int unsigned b, input bit rand_vals, input logic [31:0] fill);
    for (int i = 0; i < lbs_pkg::WORDS_PER_BONE; i++) begin
      load_word(b * lbs_pkg::WORDS_PER_BONE + i, rand_vals ? pick_value(1'b1) : fill);
    end
    if (!bone_full[b]) begin
      bone_full[b] = 1'b1;
      full_bones.push_back(b);
    end
  endtask

  task automatic skin(input logic [31:0] p, input logic [31:0] ids, input logic [31:0] wl,
                      input logic [31:0] wh, input bit rand_vec);
    lbs_pkg::in_t d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, 13'($urandom)};
    d.cmd = lbs_pkg::CMD_SKIN;
    d.pos_x = rand_vec ? pick_value(1'b0) : p;
    d.pos_y = rand_vec ? pick_value(1'b0) : p;
    d.pos_z = rand_vec ? pick_value(1'b0) : p;
    d.nrm_x = rand_vec ? pick_value(1'b0) : p;
    d.nrm_y = rand_vec ? pick_value(1'b0) : ~p;
    d.nrm_z = rand_vec ? pick_value(1'b0) : p;
    d.bone_ids = ids;
    d.weights_lo = wl;
    d.weights_hi = wh;
    send(d);
  endtask

  task automatic random_items(input int n);
    int cnt;
    int unsigned sel;
    logic [31:0] ids;
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        load_bone($urandom_range(lbs_pkg::LBS_BONES - 1), 1'b1, '0);
        cnt += lbs_pkg::WORDS_PER_BONE;
      end else if (sel < 15) begin
        load_word($urandom_range(4095, lbs_pkg::LBS_BONES * lbs_pkg::WORDS_PER_BONE),
                  $urandom);
        cnt++;
      end else if (sel < 18) begin
        load_word($urandom_range(lbs_pkg::LBS_BONES * lbs_pkg::WORDS_PER_BONE - 1),
                  pick_value(1'b1));
        cnt++;
      end else begin
        for (int k = 0; k < 4; k++) begin
          ids[8*k +: 8] = 8'(full_bones[$urandom_range(full_bones.size()-1)]);
        end
        skin('0, ids, {pick_weight(), pick_weight()}, {pick_weight(), pick_weight()}, 1'b1);
        cnt++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 17;
    rx_idle_pct = 60;
    load_bone(0, 1'b0, 32'h7FFF_FFFF);
    load_word(4095, 32'hFFFF_FFFF);
    skin(32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    skin(32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    skin(32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    load_bone(255, 1'b0, 32'h8000_0000);
    skin(32'h7FFF_FFFF, 32'hFF00_FF00, 32'h8000_FFFF, 32'h0001_7FFF, 1'b0);
    skin(32'h8000_0000, 32'h00FF_00FF, 32'hFFFF_8000, 32'h7FFF_0001, 1'b0);

    hold_cnt = 300;
    random_items(400);
    tx_idle_pct = 60;
    rx_idle_pct = 17;
    random_items(400);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_items(400);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
